@@ hw/rtl/dskh_pkg.sv @@
`timescale 1ns / 1ps
package dskh_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned ModeW = 4;
    localparam int unsigned CfgIdxW = 3;

    typedef logic [WordW-1:0] word_t;

    typedef enum logic [ModeW-1:0] {
        MODE_CRC_ROT     = 4'd0,
        MODE_ROT_XOR     = 4'd1,
        MODE_ADD_SUB     = 4'd2,
        MODE_FOLD_XOR    = 4'd3,
        MODE_JENKINS     = 4'd4,
        MODE_CRC_ROT_XOR = 4'd5,
        MODE_SEED_XOR    = 4'd6,
        MODE_CRC         = 4'd7,
        MODE_DJB         = 4'd8,
        MODE_DJB_XOR     = 4'd9,
        MODE_FNV         = 4'd10
    } mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_HASH_MODE  = 3'd0,
        REG_SEED_ONE   = 3'd1,
        REG_SEED_TWO   = 3'd2,
        REG_SEED_THREE = 3'd3,
        REG_SEED_FOUR  = 3'd4
    } cfg_index_t;

    localparam word_t CrcPoly    = 32'h82F6_3B78;
    localparam word_t GoldenWord = 32'h9E37_79B9;
    localparam word_t FnvBasis   = 32'h811C_9DC5;
    localparam word_t FnvPrime   = 32'h0100_0193;
    localparam word_t DjbMult    = 32'd33;

    // Eight CRC32C bit steps, reflected, no inversion.
    function automatic word_t crc_byte(input word_t c);
        word_t r;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            r = (r >> 1) ^ (r[0] ? CrcPoly : '0);
        end
        return r;
    endfunction

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (WordW - n));
    endfunction

    function automatic word_t fold16(input word_t x);
        return {16'd0, x[15:0] ^ x[31:16]};
    endfunction

    // One byte step of the djb / fnv chains.
    function automatic word_t chain_step(input word_t h, input logic [7:0] by,
                                         input mode_t m);
        word_t r;
        r = '0;
        case (m)
            MODE_DJB:     r = DjbMult * h + {24'd0, by};
            MODE_DJB_XOR: r = (DjbMult * h) ^ {24'd0, by};
            default:      r = (FnvPrime * h) ^ {24'd0, by};
        endcase
        return r;
    endfunction

    // Three rows of the Jenkins mix.
    function automatic logic [95:0] jmix_a(input logic [95:0] s);
        word_t a, b, c;
        a = s[31:0]; b = s[63:32]; c = s[95:64];
        a = a - b - c; a = a ^ (c >> 13);
        b = b - c - a; b = b ^ (a << 8);
        c = c - a - b; c = c ^ (b >> 13);
        return {c, b, a};
    endfunction

    function automatic logic [95:0] jmix_b(input logic [95:0] s);
        word_t a, b, c;
        a = s[31:0]; b = s[63:32]; c = s[95:64];
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 16);
        c = c - a - b; c = c ^ (b >> 5);
        return {c, b, a};
    endfunction

    function automatic logic [95:0] jmix_c(input logic [95:0] s);
        word_t a, b, c;
        a = s[31:0]; b = s[63:32]; c = s[95:64];
        a = a - b - c; a = a ^ (c >> 3);
        b = b - c - a; b = b ^ (a << 10);
        c = c - a - b; c = c ^ (b >> 15);
        return {c, b, a};
    endfunction

endpackage

@@ hw/rtl/dskh_lane.sv @@
`timescale 1ns / 1ps
// One vertex hash lane, four register stages. Stage k handles key byte k of
// the byte chains and CRC byte k; stages 0 to 2 each add one Jenkins row group.
module dskh_lane (
    input  logic                   clk,
    input  logic                   adv,
    input  dskh_pkg::mode_t        mode,
    input  dskh_pkg::word_t        key,
    input  dskh_pkg::word_t        crc_data,
    input  dskh_pkg::word_t        seed,
    input  dskh_pkg::word_t        simple,
    output dskh_pkg::word_t        hash
);
    import dskh_pkg::*;

    localparam int unsigned Stages = 4;

    mode_t       mode_reg [Stages];
    word_t       key_reg  [Stages];
    word_t       simple_reg [Stages];
    logic [95:0] st_reg   [Stages];
    logic [95:0] st_next  [Stages];

    always_comb
    begin
        for (int k = 0; k < Stages; k++)
        begin
            logic [95:0] s;
            mode_t       m;
            word_t       kk;
            s  = (k == 0) ? 96'd0 : st_reg[k-1];
            m  = (k == 0) ? mode : mode_reg[k-1];
            kk = (k == 0) ? key : key_reg[k-1];
            if (k == 0)
            begin
                case (mode)
                    MODE_JENKINS:
                        s = {seed, GoldenWord, GoldenWord + key};
                    MODE_DJB, MODE_DJB_XOR:
                        s = {64'd0, seed};
                    MODE_FNV:
                        s = {64'd0, seed ^ FnvBasis};
                    default:
                        s = {64'd0, seed ^ crc_data};
                endcase
            end
            case (m)
                MODE_JENKINS:
                begin
                    if (k == 0)
                        s = jmix_a(s);
                    else if (k == 1)
                        s = jmix_b(s);
                    else if (k == 2)
                        s = jmix_c(s);
                end
                MODE_DJB, MODE_DJB_XOR, MODE_FNV:
                    s = {64'd0, chain_step(s[31:0], kk[8*k +: 8], m)};
                default:
                    s = {64'd0, crc_byte(s[31:0])};
            endcase
            st_next[k] = s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < Stages; k++)
            begin
                st_reg[k]     <= st_next[k];
                mode_reg[k]   <= (k == 0) ? mode : mode_reg[k-1];
                key_reg[k]    <= (k == 0) ? key : key_reg[k-1];
                simple_reg[k] <= (k == 0) ? simple : simple_reg[k-1];
            end
        end
    end

    always_comb
    begin
        case (mode_reg[Stages-1])
            MODE_CRC_ROT, MODE_CRC_ROT_XOR, MODE_CRC, MODE_DJB, MODE_DJB_XOR,
            MODE_FNV:
                hash = st_reg[Stages-1][31:0];
            MODE_JENKINS:
                hash = st_reg[Stages-1][95:64];
            default:
                hash = simple_reg[Stages-1];
        endcase
    end

endmodule

@@ hw/rtl/dual_seeded_key_hash_top.sv @@
`timescale 1ns / 1ps
// Dual seeded key hash.
// A key enters on the s_axis channel (tdata = key). Each result leaves on
// the m_axis channel: tdata holds vertex_one in bits 31:0 and vertex_two in
// bits 63:32, and tuser carries the collision flag, set when both are equal.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data: index 0 hash_mode, 1..4 seed_one..seed_four. cfg_ready is always
// high; writes should be made only while no key is in flight.
// The datapath is a pipeline of nine register stages: one input stage,
// four lane stages (one key byte or Jenkins row group each), and four byte
// stages for the second CRC pass of mode 5, the last of which drives the
// outputs. One key is accepted every cycle while the pipeline advances.
// When m_axis_tready is low with a result waiting, the whole pipeline
// holds; it keeps accepting only while the output stage is empty or
// being drained, so nothing is dropped or repeated.
// Reset clears all valid bits and the configuration registers to zero.
module dual_seeded_key_hash_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,   // key
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [63:0]               m_axis_tdata,   // vertex_one, vertex_two
    output logic                      m_axis_tuser,   // collision
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dskh_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);
    import dskh_pkg::*;

    localparam int unsigned Depth = 9;

    mode_t mode_reg;
    word_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic [Depth-1:0] vld_reg;
    logic  adv;

    assign cfg_ready = 1'b1;
    assign adv = !vld_reg[Depth-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CRC_ROT;
            s1_reg <= '0; s2_reg <= '0; s3_reg <= '0; s4_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HASH_MODE:
                    mode_reg <= (cfg_data[3:0] > 4'd10) ? MODE_FNV
                                : mode_t'(cfg_data[3:0]);
                REG_SEED_ONE:   s1_reg <= cfg_data;
                REG_SEED_TWO:   s2_reg <= cfg_data;
                REG_SEED_THREE: s3_reg <= cfg_data;
                REG_SEED_FOUR:  s4_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    // Input stage: the simple schemes and the lane operands.
    word_t key_reg, d1_reg, d2_reg, p1_reg, p2_reg, key_rot;
    mode_t m0_reg;
    assign key_rot = rotl(s_axis_tdata, 15);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg <= s_axis_tdata;
            m0_reg  <= mode_reg;
            d1_reg  <= s_axis_tdata;
            d2_reg  <= (mode_reg == MODE_CRC) ? s_axis_tdata : key_rot;
            case (mode_reg)
                MODE_ROT_XOR:
                begin
                    p1_reg <= rotl(s_axis_tdata ^ s1_reg, 15)
                              ^ rotl(s_axis_tdata - s3_reg, 21);
                    p2_reg <= rotl(s_axis_tdata + s2_reg, 7)
                              ^ rotl(s_axis_tdata ^ s4_reg, 12);
                end
                MODE_ADD_SUB:
                begin
                    p1_reg <= s_axis_tdata + s1_reg;
                    p2_reg <= s_axis_tdata - s2_reg;
                end
                MODE_FOLD_XOR:
                begin
                    p1_reg <= fold16(s_axis_tdata ^ s1_reg);
                    p2_reg <= fold16(key_rot ^ s2_reg);
                end
                MODE_CRC_ROT_XOR:
                begin
                    p1_reg <= '0;
                    p2_reg <= s3_reg ^ s_axis_tdata;
                end
                default:
                begin
                    p1_reg <= s1_reg ^ s_axis_tdata;
                    p2_reg <= s2_reg ^ key_rot;
                end
            endcase
        end
    end

    word_t h1, h2;

    dskh_lane u_lane1 (
        .clk(clk), .adv(adv), .mode(m0_reg), .key(key_reg),
        .crc_data(d1_reg), .seed(s1_reg), .simple(p1_reg), .hash(h1)
    );

    // Lane two carries the extra crc operand of mode 5 in its key slot, which
    // the crc path does not use.
    dskh_lane u_lane2 (
        .clk(clk), .adv(adv), .mode(m0_reg),
        .key((m0_reg == MODE_CRC_ROT_XOR) ? p2_reg : key_reg),
        .crc_data(d2_reg), .seed(s2_reg), .simple(p2_reg), .hash(h2)
    );

    // Delay lines matched to the lane depth for the second CRC pass.
    mode_t m_dl_reg [4];
    word_t x_dl_reg [4];
    word_t h1_dl_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                m_dl_reg[k] <= (k == 0) ? m0_reg : m_dl_reg[k-1];
                x_dl_reg[k] <= (k == 0) ? p2_reg : x_dl_reg[k-1];
            end
            for (int k = 0; k < 4; k++)
                h1_dl_reg[k] <= (k == 0) ? h1 : h1_dl_reg[k-1];
        end
    end

    // Second CRC pass for mode 5: four byte stages after the lanes.
    word_t c_reg [4];
    mode_t cm_reg [4];
    word_t cp_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (k == 0)
                begin
                    c_reg[k]  <= crc_byte(h2 ^ x_dl_reg[3]);
                    cm_reg[k] <= m_dl_reg[3];
                    cp_reg[k] <= h2;
                end
                else
                begin
                    c_reg[k]  <= crc_byte(c_reg[k-1]);
                    cm_reg[k] <= cm_reg[k-1];
                    cp_reg[k] <= cp_reg[k-1];
                end
            end
        end
    end

    word_t v2;
    assign v2 = (cm_reg[3] == MODE_CRC_ROT_XOR) ? c_reg[3] : cp_reg[3];

    assign m_axis_tdata = {v2, h1_dl_reg[3]};
    assign m_axis_tuser = (v2 == h1_dl_reg[3]);

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import dskh_pkg::*;

    typedef struct packed {
        logic [31:0] v1;
        logic [31:0] v2;
        logic        coll;
    } hash_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    dual_seeded_key_hash_top DUT (.*);

    always #5 clk = ~clk;

    logic [3:0]  cur_mode;
    logic [31:0] seed [1:4];

    logic [31:0] key_queue [$];
    hash_res_t   hash_expect [$];
    int          err_count = 0;
    bit          quiet_phase = 1'b0;
    bit          sender_hold = 1'b0;
    bit          in_taken = 1'b0;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function automatic logic [31:0] crc32c_word(input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        r = c ^ d;
        for (int i = 0; i < 32; i++)
        begin
            r = r[0] ? ((r >> 1) ^ 32'h82F63B78) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [31:0] jenkins_word(input logic [31:0] k, input logic [31:0] s);
        logic [31:0] a, b, c;
        a = 32'h9e3779b9 + k; b = 32'h9e3779b9; c = s;
        a = a - b - c; a = a ^ (c >> 13);
        b = b - c - a; b = b ^ (a << 8);
        c = c - a - b; c = c ^ (b >> 13);
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 16);
        c = c - a - b; c = c ^ (b >> 5);
        a = a - b - c; a = a ^ (c >> 3);
        b = b - c - a; b = b ^ (a << 10);
        c = c - a - b; c = c ^ (b >> 15);
        return c;
    endfunction

    // Byte chains over the key, low byte first: djb add, djb xor or fnv-1.
    function automatic logic [31:0] byte_chain_hash(input logic [31:0] k, input logic [31:0] s,
                                                    input mode_t m);
        logic [31:0] h;
        logic [31:0] by;
        h = (m == MODE_FNV) ? (s ^ 32'd2166136261) : s;
        for (int i = 0; i < 4; i++)
        begin
            by = (k >> (8 * i)) & 32'hFF;
            case (m)
                MODE_DJB:     h = 32'd33 * h + by;
                MODE_DJB_XOR: h = (32'd33 * h) ^ by;
                default:      h = (32'd16777619 * h) ^ by;
            endcase
        end
        return h;
    endfunction

    function automatic hash_res_t hash_key(input logic [31:0] k);
        hash_res_t r;
        logic [31:0] x, y;
        mode_t m;
        m = (cur_mode > 4'd10) ? MODE_FNV : mode_t'(cur_mode);
        case (m)
            MODE_CRC_ROT:
            begin
                r.v1 = crc32c_word(seed[1], k);
                r.v2 = crc32c_word(seed[2], rol(k, 15));
            end
            MODE_ROT_XOR:
            begin
                r.v1 = rol(k ^ seed[1], 15) ^ rol(k - seed[3], 21);
                r.v2 = rol(k + seed[2], 7) ^ rol(k ^ seed[4], 12);
            end
            MODE_ADD_SUB:
            begin
                r.v1 = k + seed[1];
                r.v2 = k - seed[2];
            end
            MODE_FOLD_XOR:
            begin
                x = k ^ seed[1];
                y = rol(k, 15) ^ seed[2];
                r.v1 = {16'd0, x[15:0] ^ x[31:16]};
                r.v2 = {16'd0, y[15:0] ^ y[31:16]};
            end
            MODE_JENKINS:
            begin
                r.v1 = jenkins_word(k, seed[1]);
                r.v2 = jenkins_word(k, seed[2]);
            end
            MODE_CRC_ROT_XOR:
            begin
                r.v1 = crc32c_word(seed[1], k);
                r.v2 = crc32c_word(crc32c_word(seed[2], rol(k, 15)), seed[3] ^ k);
            end
            MODE_SEED_XOR:
            begin
                r.v1 = seed[1] ^ k;
                r.v2 = seed[2] ^ rol(k, 15);
            end
            MODE_CRC:
            begin
                r.v1 = crc32c_word(seed[1], k);
                r.v2 = crc32c_word(seed[2], k);
            end
            default:
            begin
                r.v1 = byte_chain_hash(k, seed[1], m);
                r.v2 = byte_chain_hash(k, seed[2], m);
            end
        endcase
        r.coll = (r.v1 == r.v2);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic bit idle_now();
        return !quiet_phase && ($urandom_range(99) < 7);
    endfunction

    // Key acceptance, seen at the rising edge where the transaction happens.
    always @(posedge clk)
    begin
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            hash_expect.push_back(hash_key(s_axis_tdata));
            void'(key_queue.pop_front());
        end
    end

    // Key driver.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
            begin
                // A waiting transaction stays on the bus unchanged.
                s_axis_tvalid <= 1'b1;
            end
            else if (!sender_hold && key_queue.size() > 0 && !idle_now())
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= key_queue[0];
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !idle_now();
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        hash_res_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (hash_expect.size() == 0)
            begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end
            else
            begin
                w = hash_expect.pop_front();
                if (m_axis_tdata[31:0] !== w.v1)
                    report_mismatch("vertex_one", m_axis_tdata[31:0], w.v1);
                if (m_axis_tdata[63:32] !== w.v2)
                    report_mismatch("vertex_two", m_axis_tdata[63:32], w.v2);
                if (m_axis_tuser !== w.coll)
                    report_mismatch("collision", {31'd0, m_axis_tuser}, {31'd0, w.coll});
            end
        end
    end

    task automatic drain();
        while (key_queue.size() > 0 || s_axis_tvalid || hash_expect.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_HASH_MODE: cur_mode = val[3:0];
            REG_SEED_ONE:  seed[1] = val;
            REG_SEED_TWO:  seed[2] = val;
            REG_SEED_THREE: seed[3] = val;
            default:       seed[4] = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input logic [3:0] m, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
        drain();
        write_reg(REG_HASH_MODE, {28'd0, m});
        write_reg(REG_SEED_ONE, a);
        write_reg(REG_SEED_TWO, b);
        write_reg(REG_SEED_THREE, c);
        write_reg(REG_SEED_FOUR, d);
    endtask

    initial
    begin
        int n;
        cur_mode = '0;
        for (int i = 1; i <= 4; i++)
            seed[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: key extremes under reset settings, then every mode.
        key_queue.push_back(32'h0);
        key_queue.push_back(32'hFFFFFFFF);
        key_queue.push_back(32'h80000001);
        for (int m = 0; m < 16; m++)
        begin
            set_all(m[3:0], $urandom, $urandom, $urandom, $urandom);
            key_queue.push_back(32'h0);
            key_queue.push_back(32'hFFFFFFFF);
        end
        // Equal seeds in MODE_CRC, and opposite seeds one and two in MODE_ADD_SUB, give colliding hashes.
        set_all(MODE_CRC, 32'h1234, 32'h1234, 0, 0);
        key_queue.push_back($urandom);
        set_all(MODE_ADD_SUB, 32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        key_queue.push_back(32'h5);

        // The sender holds off until every result is back.
        drain();
        for (int i = 0; i < 40; i++)
            key_queue.push_back($urandom);
        while (hash_expect.size() < 4)
            @(posedge clk);
        sender_hold = 1'b1;
        while (hash_expect.size() > 0)
            @(posedge clk);
        sender_hold = 1'b0;

        for (int ph = 0; ph < 16; ph++)
        begin
            set_all(4'($urandom_range(15)), (ph % 4 == 0) ? 32'h0 : $urandom,
                    (ph % 4 == 1) ? 32'hFFFFFFFF : $urandom, $urandom, $urandom);
            quiet_phase = (ph == 5);
            n = 100;
            for (int i = 0; i < n; i++)
                key_queue.push_back(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom);
        end
        drain();
        quiet_phase = 1'b0;
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("testbench: done, errors");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/dskh_pkg.sv
hw/rtl/dskh_lane.sv
hw/rtl/dual_seeded_key_hash_top.sv
verif/testbench.sv
